@@ design/bfer_pkg.sv @@
// Shared types, constants and saturating arithmetic for the bit and frame error rate counter.
`timescale 1ns / 1ps
package bfer_pkg;

  // Per-slot counter storage.
  localparam int SLOT_COUNT = 64;
  localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Field widths.
  localparam int CMD_W      = 2;
  localparam int VAL_W      = 8;
  localparam int SLOT_W     = 6;
  localparam int ERRS_W     = 16;
  localparam int FB_W       = 16;
  localparam int MFE_W      = 20;
  localparam int BITS_W     = 48;
  localparam int FRAMES_W   = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Exact rate comparison: bit errors scaled by 1e6 .. 1e9 against
  // frames * frame_bits. The largest product, (2^48 - 1) * 1e9, needs 78 bits.
  localparam int              PROD_W   = 79;
  localparam int              RHS_W    = 56;
  localparam int              POW6_W   = 20;
  localparam logic [POW6_W-1:0] POW6   = 20'd1000000;
  localparam int              BE_SPLIT = 24;
  localparam int              FT_SPLIT = 20;

  // Number of payload stages that follow the slot read-modify-write stage.
  localparam int PIPE_DEPTH = 5;
  localparam int PIPE_LAST  = PIPE_DEPTH - 1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_VALUE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SUMMARY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BITS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRM_ERR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_LIMIT  = 2'd2;

  // Configuration reset values.
  localparam logic [FB_W-1:0]  FRAME_BITS_RST  = 16'd1;
  localparam logic [MFE_W-1:0] MAX_FRM_ERR_RST = 20'd200;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [VAL_W-1:0]  bit_value;
    logic [SLOT_W-1:0] frame_slot;
    logic [ERRS_W-1:0] error_count;
  } in_word_t;

  typedef struct packed {
    logic                frame_done;
    logic [BITS_W-1:0]   total_bit_errors;
    logic [FRAMES_W-1:0] total_frame_errors;
    logic [FRAMES_W-1:0] frames_analyzed;
    logic [BITS_W-1:0]   slot_bit_total;
    logic [FRAMES_W-1:0] slot_frame_total;
    logic [MFE_W-1:0]    error_limit;
    logic                limit_reached;
  } out_word_t;

  // What the frame accumulator tells the slot store about one word.
  typedef struct packed {
    logic              done;
    logic              slot_upd;
    logic [ERRS_W-1:0] errs;
  } frame_upd_t;

  // One slot request held during the read-modify-write stage.
  typedef struct packed {
    logic               valid;
    logic               ok;
    logic               upd;
    logic [SLOT_AW-1:0] addr;
    logic [ERRS_W-1:0]  errs;
  } slot_req_t;

  // Contents of one slot entry.
  typedef struct packed {
    logic [BITS_W-1:0]   bits;
    logic [FRAMES_W-1:0] frames;
  } slot_val_t;

  // Payload carried down the pipeline alongside the rate comparison.
  typedef struct packed {
    logic                done;
    logic [BITS_W-1:0]   tbe;
    logic [FRAMES_W-1:0] tfe;
    logic [FRAMES_W-1:0] tfa;
    logic [BITS_W-1:0]   sbt;
    logic [FRAMES_W-1:0] sft;
  } pipe_word_t;

  function automatic logic [BITS_W-1:0] sat_add48(input logic [BITS_W-1:0] a,
                                                  input logic [ERRS_W-1:0] b);
    logic [BITS_W:0] s;
    s = {1'b0, a} + (BITS_W + 1)'(b);
    return s[BITS_W] ? {BITS_W{1'b1}} : s[BITS_W-1:0];
  endfunction

  function automatic logic [FRAMES_W-1:0] sat_inc40(input logic [FRAMES_W-1:0] a,
                                                    input logic inc);
    logic [FRAMES_W:0] s;
    s = {1'b0, a} + (FRAMES_W + 1)'(inc);
    return s[FRAMES_W] ? {FRAMES_W{1'b1}} : s[FRAMES_W-1:0];
  endfunction

endpackage

@@ design/bfer_frame_acc.sv @@
// Frame position tracking and saturating running totals.
`timescale 1ns / 1ps
module bfer_frame_acc (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  bfer_pkg::in_word_t             in_word,
  input  logic [bfer_pkg::FB_W-1:0]      frame_bits,
  output bfer_pkg::frame_upd_t           upd,
  output logic [bfer_pkg::BITS_W-1:0]    bit_err_total,
  output logic [bfer_pkg::FRAMES_W-1:0]  frame_err_total,
  output logic [bfer_pkg::FRAMES_W-1:0]  frame_total
);
  import bfer_pkg::*;

  logic [FB_W-1:0]     bit_pos_r, bit_pos_nxt;
  logic [ERRS_W-1:0]   cur_err_r, cur_err_nxt;
  logic [BITS_W-1:0]   be_r, be_nxt;
  logic [FRAMES_W-1:0] fe_r, fe_nxt;
  logic [FRAMES_W-1:0] ft_r, ft_nxt;
  logic [FB_W-1:0]     eff_fb;
  logic [ERRS_W-1:0]   err_inc;
  logic                closing;

  always_comb begin
    eff_fb  = (frame_bits == '0) ? FB_W'(1) : frame_bits;
    err_inc = (in_word.bit_value != '0 && cur_err_r != {ERRS_W{1'b1}}) ?
              cur_err_r + ERRS_W'(1) : cur_err_r;
    closing = ({1'b0, bit_pos_r} + (FB_W + 1)'(1)) >= {1'b0, eff_fb};

    bit_pos_nxt = bit_pos_r;
    cur_err_nxt = cur_err_r;
    be_nxt      = be_r;
    fe_nxt      = fe_r;
    ft_nxt      = ft_r;
    upd         = '0;

    case (in_word.cmd)
      CMD_VALUE: begin
        if (closing) begin
          upd.done     = 1'b1;
          upd.slot_upd = 1'b1;
          upd.errs     = err_inc;
          be_nxt       = sat_add48(be_r, err_inc);
          fe_nxt       = sat_inc40(fe_r, err_inc != '0);
          ft_nxt       = sat_inc40(ft_r, 1'b1);
          bit_pos_nxt  = '0;
          cur_err_nxt  = '0;
        end else begin
          bit_pos_nxt = bit_pos_r + FB_W'(1);
          cur_err_nxt = err_inc;
        end
      end
      CMD_SUMMARY: begin
        upd.done = 1'b1;
        upd.errs = in_word.error_count;
        be_nxt   = sat_add48(be_r, in_word.error_count);
        fe_nxt   = sat_inc40(fe_r, in_word.error_count != '0);
        ft_nxt   = sat_inc40(ft_r, 1'b1);
      end
      CMD_CLEAR: begin
        be_nxt = '0;
        fe_nxt = '0;
        ft_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_pos_r <= '0;
      cur_err_r <= '0;
      be_r      <= '0;
      fe_r      <= '0;
      ft_r      <= '0;
    end else if (accept) begin
      bit_pos_r <= bit_pos_nxt;
      cur_err_r <= cur_err_nxt;
      be_r      <= be_nxt;
      fe_r      <= fe_nxt;
      ft_r      <= ft_nxt;
    end
  end

  assign bit_err_total   = be_r;
  assign frame_err_total = fe_r;
  assign frame_total     = ft_r;

endmodule

@@ design/bfer_slot_store.sv @@
// Per-slot counter memory with read-modify-write and write-to-read forwarding.
`timescale 1ns / 1ps
module bfer_slot_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          accept,
  input  logic [bfer_pkg::SLOT_W-1:0]   slot,
  input  bfer_pkg::frame_upd_t          upd,
  output bfer_pkg::slot_val_t           slot_res
);
  import bfer_pkg::*;

  slot_val_t              slot_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]  valid_r;
  slot_val_t              rdata_r;
  logic                   rvalid_r;
  slot_req_t              req_r, req_nxt;
  logic                   fwd_valid_r;
  logic [SLOT_AW-1:0]     fwd_addr_r;
  slot_val_t              fwd_data_r;

  logic                   ok;
  logic [SLOT_AW-1:0]     addr;
  logic                   rd_en;
  logic                   wr_en;
  logic                   fwd_hit;
  slot_val_t              old_val;
  slot_val_t              new_val;

  always_comb begin
    ok    = 32'(slot) < SLOT_COUNT;
    addr  = SLOT_AW'(slot);
    rd_en = accept && ok;

    req_nxt.valid = accept;
    req_nxt.ok    = ok;
    req_nxt.upd   = upd.slot_upd && ok;
    req_nxt.addr  = addr;
    req_nxt.errs  = upd.errs;

    // The entry written at the edge that read this request's data is newer
    // than what the memory returned.
    fwd_hit = fwd_valid_r && (fwd_addr_r == req_r.addr);
    if (fwd_hit) begin
      old_val = fwd_data_r;
    end else if (rvalid_r) begin
      old_val = rdata_r;
    end else begin
      old_val = '0;
    end

    if (req_r.upd) begin
      new_val.bits   = sat_add48(old_val.bits, req_r.errs);
      new_val.frames = sat_inc40(old_val.frames, req_r.errs != '0);
    end else begin
      new_val = old_val;
    end

    wr_en    = adv && req_r.valid && req_r.upd;
    slot_res = req_r.ok ? new_val : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      req_r       <= '0;
      fwd_valid_r <= 1'b0;
    end else if (adv) begin
      req_r       <= req_nxt;
      fwd_valid_r <= wr_en;
      if (wr_en) begin
        valid_r[req_r.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[req_r.addr] <= new_val;
    end
    if (rd_en) begin
      rdata_r  <= slot_mem[addr];
      rvalid_r <= valid_r[addr];
    end
    if (adv) begin
      fwd_addr_r <= req_r.addr;
      fwd_data_r <= new_val;
    end
  end

endmodule

@@ design/bfer_limit.sv @@
// Pipelined exact bit error rate decade test and frame error limit scaling.
`timescale 1ns / 1ps
module bfer_limit (
  input  logic                           clk,
  input  logic                           adv,
  input  logic [bfer_pkg::BITS_W-1:0]    bit_err_total,
  input  logic [bfer_pkg::FRAMES_W-1:0]  frame_total,
  input  logic [bfer_pkg::FB_W-1:0]      frame_bits,
  input  logic [bfer_pkg::MFE_W-1:0]     max_frame_errors,
  input  logic                           auto_limit,
  input  logic [bfer_pkg::FRAMES_W-1:0]  frame_err_last,
  output logic [bfer_pkg::MFE_W-1:0]     error_limit,
  output logic                           limit_reached
);
  import bfer_pkg::*;

  localparam int PP_W = BE_SPLIT + POW6_W;
  localparam int RP_W = FT_SPLIT + FB_W;

  function automatic logic [PROD_W-1:0] times10(input logic [PROD_W-1:0] x);
    return (x << 3) + (x << 1);
  endfunction

  logic [FB_W-1:0]   eff_fb;
  logic [PP_W-1:0]   p_lo, p_hi;
  logic [RP_W-1:0]   r_lo, r_hi;

  // Partial products.
  logic [PP_W-1:0]   p_lo_r, p_hi_r;
  logic [RP_W-1:0]   r_lo_r, r_hi_r;
  logic              nz2_r;
  // Bit errors times 1e6, 1e7, 1e8, 1e9.
  logic [PROD_W-1:0] b6_r, b7_r, b8_r, b9_r;
  logic [RHS_W-1:0]  rhs3_r, rhs4_r, rhs5_r, rhs6_r;
  logic              nz3_r, nz4_r, nz5_r, nz6_r;
  logic              lt6_4_r, lt6_5_r, lt6_6_r;
  logic              lt7_5_r, lt7_6_r;
  logic              lt8_6_r;
  logic              lt9;

  always_comb begin
    eff_fb = (frame_bits == '0) ? FB_W'(1) : frame_bits;
    p_lo   = PP_W'(bit_err_total[BE_SPLIT-1:0]) * PP_W'(POW6);
    p_hi   = PP_W'(bit_err_total[BITS_W-1:BE_SPLIT]) * PP_W'(POW6);
    r_lo   = RP_W'(frame_total[FT_SPLIT-1:0]) * RP_W'(eff_fb);
    r_hi   = RP_W'(frame_total[FRAMES_W-1:FT_SPLIT]) * RP_W'(eff_fb);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_lo_r  <= p_lo;
      p_hi_r  <= p_hi;
      r_lo_r  <= r_lo;
      r_hi_r  <= r_hi;
      nz2_r   <= frame_total != '0;

      b6_r    <= PROD_W'(p_lo_r) + (PROD_W'(p_hi_r) << BE_SPLIT);
      rhs3_r  <= RHS_W'(r_lo_r) + (RHS_W'(r_hi_r) << FT_SPLIT);
      nz3_r   <= nz2_r;

      b7_r    <= times10(b6_r);
      lt6_4_r <= b6_r < PROD_W'(rhs3_r);
      rhs4_r  <= rhs3_r;
      nz4_r   <= nz3_r;

      b8_r    <= times10(b7_r);
      lt7_5_r <= b7_r < PROD_W'(rhs4_r);
      lt6_5_r <= lt6_4_r;
      rhs5_r  <= rhs4_r;
      nz5_r   <= nz4_r;

      b9_r    <= times10(b8_r);
      lt8_6_r <= b8_r < PROD_W'(rhs5_r);
      lt7_6_r <= lt7_5_r;
      lt6_6_r <= lt6_5_r;
      rhs6_r  <= rhs5_r;
      nz6_r   <= nz5_r;
    end
  end

  always_comb begin
    lt9 = b9_r < PROD_W'(rhs6_r);
    if (!auto_limit || !nz6_r) begin
      error_limit = max_frame_errors;
    end else if (lt9) begin
      error_limit = max_frame_errors >> 4;
    end else if (lt8_6_r) begin
      error_limit = max_frame_errors >> 3;
    end else if (lt7_6_r) begin
      error_limit = max_frame_errors >> 2;
    end else if (lt6_6_r) begin
      error_limit = max_frame_errors >> 1;
    end else begin
      error_limit = max_frame_errors;
    end
    limit_reached = frame_err_last >= FRAMES_W'(error_limit);
  end

endmodule

@@ design/bit_frame_error_rate_counter_core.sv @@
// Bit and frame error rate counter top level: one word per cycle while in_stall is low.
// Path: an accepted word passes stage one and the payload stages, then the output register.
// Throughput: one word per cycle, except while in_stall is high with the skid entry full.
// Back-pressure: one skid entry behind the output register; in_stall rises when it fills.
// Reset (rst_n low, synchronous) restores register defaults, zeroes all totals and marks
// every slot entry unwritten, so slot counters read as zero until first updated.
`timescale 1ns / 1ps
module bit_frame_error_rate_counter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bfer_pkg::in_word_t                in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bfer_pkg::out_word_t               out_word,
  input  logic                              cfg_we,
  input  logic [bfer_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [bfer_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import bfer_pkg::*;

  // Configuration registers.
  logic [FB_W-1:0]     frame_bits_r;
  logic [MFE_W-1:0]    max_frame_errors_r;
  logic                auto_limit_r;

  // Pipeline control and payload.
  logic                adv;
  logic                accept;
  logic                s1_valid_r;
  logic                s1_done_r;
  logic [PIPE_DEPTH-1:0] pipe_valid_r;
  pipe_word_t          pipe_r [PIPE_DEPTH];

  // Output register and skid entry.
  logic                out_valid_r;
  out_word_t           out_word_r;
  logic                skid_valid_r;
  out_word_t           skid_r;
  out_word_t           last_word;
  logic                out_free;

  // Submodule connections.
  frame_upd_t          upd;
  logic [BITS_W-1:0]   bit_err_total;
  logic [FRAMES_W-1:0] frame_err_total;
  logic [FRAMES_W-1:0] frame_total;
  slot_val_t           slot_res;
  logic [MFE_W-1:0]    error_limit;
  logic                limit_reached;

  // The whole pipeline moves in lock step. It halts only while the skid entry
  // holds a word, which happens once the output register is stalled and a
  // further result has already left the last stage.
  assign adv      = !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign accept   = in_valid && adv;

  // Configuration writes. Unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_bits_r       <= FRAME_BITS_RST;
      max_frame_errors_r <= MAX_FRM_ERR_RST;
      auto_limit_r       <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FRAME_BITS:  frame_bits_r       <= cfg_wdata[FB_W-1:0];
        CFG_MAX_FRM_ERR: max_frame_errors_r <= cfg_wdata[MFE_W-1:0];
        CFG_AUTO_LIMIT:  auto_limit_r       <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // The accumulator updates position and totals at the accept edge, so in the
  // following cycle (stage one) its registers hold the totals after this word.
  bfer_frame_acc u_frame_acc (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .in_word         (in_word),
    .frame_bits      (frame_bits_r),
    .upd             (upd),
    .bit_err_total   (bit_err_total),
    .frame_err_total (frame_err_total),
    .frame_total     (frame_total)
  );

  // The slot memory is read at the accept edge; stage one adds the closed
  // frame and writes the entry back, forwarding to a word on the same slot
  // that was read in the same edge.
  bfer_slot_store u_slot_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .accept   (accept),
    .slot     (in_word.frame_slot),
    .upd      (upd),
    .slot_res (slot_res)
  );

  // Stage one feeds the rate comparison, whose decision arrives together
  // with the last payload stage.
  bfer_limit u_limit (
    .clk              (clk),
    .adv              (adv),
    .bit_err_total    (bit_err_total),
    .frame_total      (frame_total),
    .frame_bits       (frame_bits_r),
    .max_frame_errors (max_frame_errors_r),
    .auto_limit       (auto_limit_r),
    .frame_err_last   (pipe_r[PIPE_LAST].tfe),
    .error_limit      (error_limit),
    .limit_reached    (limit_reached)
  );

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      pipe_valid_r <= '0;
    end else if (adv) begin
      s1_valid_r   <= accept;
      pipe_valid_r <= {pipe_valid_r[PIPE_DEPTH-2:0], s1_valid_r};
    end
  end

  // Pipeline payload: totals and slot counters travel alongside the rate test.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_done_r     <= upd.done;
      pipe_r[0].done <= s1_done_r;
      pipe_r[0].tbe  <= bit_err_total;
      pipe_r[0].tfe  <= frame_err_total;
      pipe_r[0].tfa  <= frame_total;
      pipe_r[0].sbt  <= slot_res.bits;
      pipe_r[0].sft  <= slot_res.frames;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        pipe_r[i] <= pipe_r[i-1];
      end
    end
  end

  always_comb begin
    last_word.frame_done         = pipe_r[PIPE_LAST].done;
    last_word.total_bit_errors   = pipe_r[PIPE_LAST].tbe;
    last_word.total_frame_errors = pipe_r[PIPE_LAST].tfe;
    last_word.frames_analyzed    = pipe_r[PIPE_LAST].tfa;
    last_word.slot_bit_total     = pipe_r[PIPE_LAST].sbt;
    last_word.slot_frame_total   = pipe_r[PIPE_LAST].sft;
    last_word.error_limit        = error_limit;
    last_word.limit_reached      = limit_reached;
  end

  // Output register with one skid entry. When the output register is free it
  // takes the skid word first, otherwise the word leaving the last stage. When
  // it is stalled, a word leaving the last stage parks in the skid entry.
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= pipe_valid_r[PIPE_LAST];
      end
    end else if (adv && pipe_valid_r[PIPE_LAST]) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_word_r <= skid_r;
      end else begin
        out_word_r <= last_word;
      end
    end else if (adv && pipe_valid_r[PIPE_LAST]) begin
      skid_r <= last_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // The skid entry only fills while the output register is held.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid entry filled while the output register was free");

  // A word that closes a frame always leaves at least one analyzed frame.
  a_done_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.frame_done) |-> (out_word_r.frames_analyzed != '0))
    else $error("frame closed without an analyzed frame");

  // The limit flag agrees with the totals and limit it travels with.
  a_limit_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.limit_reached ==
                     (out_word_r.total_frame_errors >= FRAMES_W'(out_word_r.error_limit))))
    else $error("limit flag disagrees with frame error total");

endmodule
